>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the reorder receiver RTL. Empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked every clock, skipped while reset is held.
`define SRRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property checked every clock, reset included.
`define SRRR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define SRRR_ASSERT(label, prop, msg)
`define SRRR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> src/srrr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srrr_pkg
// Constants, types and helpers of the selective-repeat reorder receiver.
// ---------------------------------------------------------------------------
package srrr_pkg;

    localparam int WINDOW_SIZE = 2;
    localparam int HANDLE_BITS = 16;

    localparam int NSLOTS = 2 * WINDOW_SIZE;
    localparam int IDX_W  = $clog2(NSLOTS);
    localparam int SEQ_W  = $clog2(NSLOTS + 1);
    localparam int CNT_W  = $clog2(NSLOTS);
    localparam int HND_W  = 16;
    localparam int BYTE_W = 8;

    // only the low HANDLE_BITS of a handle are kept
    localparam logic [HND_W-1:0] H_MASK = (HANDLE_BITS >= HND_W) ? {HND_W{1'b1}} :
        HND_W'((64'd1 << HANDLE_BITS) - 64'd1);

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_DUP     = 2'd2,
        KIND_INVALID = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_DRAIN,
        S_ACK
    } t_state;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [HND_W-1:0] wr_handle;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
    } t_slot_ctl;

    // next sequence number with wrap from NSLOTS back to 1
    function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] s);
        next_seq = (s == SEQ_W'(NSLOTS)) ? SEQ_W'(1) : SEQ_W'(s + SEQ_W'(1));
    endfunction

endpackage

>>> src/srrr_slot_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srrr_slot_store
// Hold slots for out-of-order packets: a valid bit and a handle per slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srrr_slot_store
    import srrr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_slot_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [NSLOTS-1:0] o_valid,
    output logic [HND_W-1:0] o_rd_handle
);

    logic [NSLOTS-1:0] r_valid;
    logic [NSLOTS-1:0] n_valid;
    logic [HND_W-1:0]  r_handle [NSLOTS];

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.clr_en) begin
            n_valid[i_ctl.clr_idx] = 1'b0;
        end
        if (i_ctl.wr_en) begin
            n_valid[i_ctl.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // handle payload, no reset: only read behind a set valid bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_handle[i_ctl.wr_idx] <= i_ctl.wr_handle;
        end
    end

    assign o_valid     = r_valid;
    assign o_rd_handle = r_handle[i_rd_idx];

    `SRRR_ASSERT(a_no_wr_clr_same, !(i_ctl.wr_en && i_ctl.clr_en), "slot write and clear together")
    `SRRR_ASSERT(a_wr_free_slot, i_ctl.wr_en |-> !r_valid[i_ctl.wr_idx], "write to an occupied slot")
    `SRRR_ASSERT(a_clr_held_slot, i_ctl.clr_en |-> r_valid[i_ctl.clr_idx], "drain of an empty slot")

endmodule

>>> src/selective_repeat_reorder_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_repeat_reorder_receiver
// Receiver side of a selective-repeat scheme: in-order delivery, hold and
// drain of out-of-order packets, duplicate and invalid-number drops, acks.
// ---------------------------------------------------------------------------
// One packet descriptor is taken at a time; o_in_stall stays high until its
// last result beat is loaded into the output register. A descriptor is
// accepted, then gives its first result, then one beat per drained held slot
// until the drain ends, then the acknowledge. A held packet gives no first
// result and no drain, a duplicate no drain, and an invalid number only its
// first result; an in-order one drains up to 2*WINDOW_SIZE-1 held slots. The
// output side can stall each result. The drain walks the slot store through
// one shared increment-and-compare step per cycle while the output is free.
`include "assert_macros.svh"

module selective_repeat_reorder_receiver
    import srrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_seq_num,
    input  logic [BYTE_W-1:0] i_window_num,
    input  logic [HND_W-1:0]  i_buffer_handle,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic [HND_W-1:0]  o_out_handle,
    output logic [BYTE_W-1:0] o_out_seq,
    output logic              o_last
);

    t_state r_state, n_state;

    logic [BYTE_W-1:0] r_seq;
    logic [BYTE_W-1:0] r_win;
    logic [HND_W-1:0]  r_handle;

    logic [SEQ_W-1:0]  r_exp_seq, n_exp_seq;
    logic [BYTE_W-1:0] r_cur_win, n_cur_win;
    logic [NSLOTS-1:0] r_rcv, n_rcv;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_kind, n_kind;
    logic [HND_W-1:0]  r_out_handle, n_out_handle;
    logic [BYTE_W-1:0] r_out_seq, n_out_seq;
    logic              r_last, n_last;

    t_slot_ctl         slot_ctl;
    logic [NSLOTS-1:0] slot_valid;
    logic [HND_W-1:0]  slot_handle;
    logic [IDX_W-1:0]  exp_idx;

    logic              in_acc;
    logic              out_free;
    logic              seq_bad;
    logic              seq_exp;
    logic [IDX_W-1:0]  seq_idx;
    logic [NSLOTS-1:0] rcv_eff;
    logic              drain_go;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign seq_bad  = (r_seq == '0) || (r_seq > BYTE_W'(NSLOTS));
    assign seq_exp  = (r_seq == BYTE_W'(r_exp_seq));
    assign seq_idx  = IDX_W'(r_seq - BYTE_W'(1));
    assign exp_idx  = IDX_W'(r_exp_seq - SEQ_W'(1));
    assign rcv_eff  = (r_win != r_cur_win) ? '0 : r_rcv;
    assign drain_go = slot_valid[exp_idx] && (r_cnt != CNT_W'(NSLOTS - 1));

    srrr_slot_store u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (slot_ctl),
        .i_rd_idx    (exp_idx),
        .o_valid     (slot_valid),
        .o_rd_handle (slot_handle)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_FIRST;
            end
            S_FIRST: begin
                priority if (seq_bad) begin
                    if (out_free) n_state = S_IDLE;
                end else if (seq_exp) begin
                    if (out_free) n_state = S_DRAIN;
                end else if (rcv_eff[seq_idx] || slot_valid[seq_idx]) begin
                    if (out_free) n_state = S_ACK;
                end else begin
                    n_state = S_ACK;
                end
            end
            S_DRAIN: begin
                if (!drain_go) n_state = S_ACK;
            end
            S_ACK: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result beats
    always_comb begin
        n_exp_seq    = r_exp_seq;
        n_cur_win    = r_cur_win;
        n_rcv        = r_rcv;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_kind       = r_kind;
        n_out_handle = r_out_handle;
        n_out_seq    = r_out_seq;
        n_last       = r_last;
        slot_ctl     = '0;
        slot_ctl.wr_idx    = seq_idx;
        slot_ctl.wr_handle = r_handle & H_MASK;
        slot_ctl.clr_idx   = exp_idx;
        unique case (r_state)
            S_IDLE: begin
            end
            S_FIRST: begin
                priority if (seq_bad) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_kind       = KIND_INVALID;
                        n_out_handle = r_handle & H_MASK;
                        n_out_seq    = r_seq;
                        n_last       = 1'b1;
                    end
                end else if (seq_exp) begin
                    if (out_free) begin
                        n_cur_win          = r_win;
                        n_rcv              = rcv_eff;
                        n_rcv[seq_idx]     = 1'b1;
                        n_exp_seq          = next_seq(r_exp_seq);
                        n_cnt              = '0;
                        n_out_valid        = 1'b1;
                        n_kind             = KIND_DELIVER;
                        n_out_handle       = r_handle & H_MASK;
                        n_out_seq          = r_seq;
                        n_last             = 1'b0;
                    end
                end else if (rcv_eff[seq_idx] || slot_valid[seq_idx]) begin
                    if (out_free) begin
                        n_cur_win      = r_win;
                        n_rcv          = rcv_eff;
                        n_rcv[seq_idx] = 1'b1;
                        n_out_valid    = 1'b1;
                        n_kind         = KIND_DUP;
                        n_out_handle   = r_handle & H_MASK;
                        n_out_seq      = r_seq;
                        n_last         = 1'b0;
                    end
                end else begin
                    // unseen, out of order: park it
                    n_cur_win      = r_win;
                    n_rcv          = rcv_eff;
                    n_rcv[seq_idx] = 1'b1;
                    slot_ctl.wr_en = 1'b1;
                end
            end
            S_DRAIN: begin
                if (drain_go && out_free) begin
                    slot_ctl.clr_en = 1'b1;
                    n_exp_seq       = next_seq(r_exp_seq);
                    n_cnt           = CNT_W'(r_cnt + CNT_W'(1));
                    n_out_valid     = 1'b1;
                    n_kind          = KIND_DELIVER;
                    n_out_handle    = slot_handle;
                    n_out_seq       = BYTE_W'(r_exp_seq);
                    n_last          = 1'b0;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_kind       = KIND_ACK;
                    n_out_handle = '0;
                    n_out_seq    = r_seq;
                    n_last       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp_seq   <= SEQ_W'(1);
            r_cur_win   <= '0;
            r_rcv       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp_seq   <= n_exp_seq;
            r_cur_win   <= n_cur_win;
            r_rcv       <= n_rcv;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_seq    <= i_seq_num;
            r_win    <= i_window_num;
            r_handle <= i_buffer_handle;
        end
        r_kind       <= n_kind;
        r_out_handle <= n_out_handle;
        r_out_seq    <= n_out_seq;
        r_last       <= n_last;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_handle = r_out_handle;
    assign o_out_seq    = r_out_seq;
    assign o_last       = r_last;

    `SRRR_ASSERT(a_exp_range, (r_exp_seq != '0) && (r_exp_seq <= SEQ_W'(NSLOTS)), "expected seq out of range")
    `SRRR_ASSERT(a_ack_last, (o_out_valid && (o_kind == KIND_ACK)) |-> o_last, "ack beat not last")
    `SRRR_ASSERT(a_accept_first, in_acc |=> (r_state == S_FIRST), "accepted beat not classified")

endmodule

>>> tb/selective_repeat_reorder_receiver_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// selective_repeat_reorder_receiver_test
// Self-checking bench for the reorder receiver. A directed table covers
// reset, invalid numbers, repeats, holds, full drains with wrap, numbers seen
// before a window change and window extremes. A random run follows
// under four idling phases and one long output hold-off. Every output beat
// is checked in order against a behavioral model or typed beats of a table row.
// ---------------------------------------------------------------------------
module selective_repeat_reorder_receiver_test;
    import srrr_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int ITEMS_PER_MODE = 32;

    // idling modes
    localparam int MODE_NONE = 0;
    localparam int MODE_TX   = 1;
    localparam int MODE_RX   = 2;
    localparam int MODE_BOTH = 3;

    typedef struct {
        t_kind             kind;
        logic [HND_W-1:0]  handle;
        logic [BYTE_W-1:0] seq;
        logic              last;
    } t_beat;

    // ntyped: 0 = checked against the model, 1 = single typed beat,
    // 2 = typed beat followed by the acknowledge
    typedef struct packed {
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] win;
        logic [HND_W-1:0]  hnd;
        logic [1:0]        ntyped;
        t_kind             k0;
    } t_row;

    localparam int NROWS = 25;
    localparam t_row DIR_ROWS [NROWS] = '{
        '{8'd1,   8'd0,   16'h0000, 2'd2, KIND_DELIVER},  // first after reset
        '{8'd0,   8'd0,   16'hFFFF, 2'd1, KIND_INVALID},
        '{8'd255, 8'd0,   16'hA5A5, 2'd1, KIND_INVALID},
        '{8'd5,   8'd0,   16'h5A5A, 2'd1, KIND_INVALID},  // just above 2W
        '{8'd1,   8'd0,   16'h1234, 2'd2, KIND_DUP},      // repeat
        '{8'd3,   8'd0,   16'h3333, 2'd0, KIND_ACK},
        '{8'd4,   8'd0,   16'h4444, 2'd0, KIND_ACK},
        '{8'd3,   8'd0,   16'h3A3A, 2'd0, KIND_ACK},
        '{8'd2,   8'd0,   16'hFFFF, 2'd0, KIND_ACK},      // drain 3,4 with wrap
        '{8'd2,   8'd1,   16'h2222, 2'd0, KIND_ACK},
        '{8'd3,   8'd1,   16'h3333, 2'd0, KIND_ACK},
        '{8'd4,   8'd1,   16'h4444, 2'd0, KIND_ACK},
        '{8'd1,   8'd1,   16'h1111, 2'd0, KIND_ACK},      // longest drain
        '{8'd3,   8'd1,   16'hC3C3, 2'd0, KIND_ACK},
        '{8'd3,   8'd2,   16'hD3D3, 2'd0, KIND_ACK},      // seen bit from old window cleared
        '{8'd3,   8'd2,   16'hE3E3, 2'd0, KIND_ACK},
        '{8'd1,   8'd2,   16'h0101, 2'd0, KIND_ACK},
        '{8'd2,   8'd2,   16'h0202, 2'd0, KIND_ACK},
        '{8'd4,   8'd3,   16'h0404, 2'd0, KIND_ACK},
        '{8'd2,   8'd3,   16'h0B0B, 2'd0, KIND_ACK},
        '{8'd3,   8'd3,   16'h0C0C, 2'd0, KIND_ACK},
        '{8'd1,   8'd3,   16'h0A0A, 2'd0, KIND_ACK},
        '{8'd4,   8'd3,   16'hFFFF, 2'd0, KIND_ACK},      // expected, bit already set
        '{8'd7,   8'd255, 16'hFFFF, 2'd1, KIND_INVALID},  // window must not change
        '{8'd1,   8'd255, 16'h8000, 2'd0, KIND_ACK}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_seq_num = '0;
    logic [BYTE_W-1:0] i_window_num = '0;
    logic [HND_W-1:0]  i_buffer_handle = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_kind;
    logic [HND_W-1:0]  o_out_handle;
    logic [BYTE_W-1:0] o_out_seq;
    logic              o_last;

    // bench-side tags that travel with the current input beat
    logic [1:0] cur_ntyped = '0;
    t_kind      cur_k0 = KIND_ACK;

    int idle_mode = MODE_NONE;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int fails = 0;

    // receiver model state
    int unsigned       rx_expected = 1;
    logic [BYTE_W-1:0] rx_window = '0;
    logic [NSLOTS-1:0] rx_seen = '0;
    logic [NSLOTS-1:0] rx_held = '0;
    logic [HND_W-1:0]  rx_held_hnd [NSLOTS];

    t_beat new_beats [$];
    t_beat expected_beats [$];

    selective_repeat_reorder_receiver i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_seq_num       (i_seq_num),
        .i_window_num    (i_window_num),
        .i_buffer_handle (i_buffer_handle),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_out_handle    (o_out_handle),
        .o_out_seq       (o_out_seq),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    function automatic void add_beat(input t_kind kind, input logic [HND_W-1:0] hnd,
                                     input logic [BYTE_W-1:0] seq, input logic last);
        t_beat b;
        b.kind   = kind;
        b.handle = hnd & H_MASK;
        b.seq    = seq;
        b.last   = last;
        new_beats.push_back(b);
    endfunction

    // one packet through the receiver model; results land in new_beats
    function automatic void reorder_predict(input logic [BYTE_W-1:0] seq,
                                            input logic [BYTE_W-1:0] win,
                                            input logic [HND_W-1:0] hnd);
        int unsigned idx;
        logic [HND_W-1:0] h;
        h = hnd & H_MASK;
        new_beats.delete();
        if (seq < 1 || seq > NSLOTS) begin
            add_beat(KIND_INVALID, h, seq, 1'b1);
            return;
        end
        if (win != rx_window) begin
            rx_seen   = '0;
            rx_window = win;
        end
        if (seq == rx_expected) begin
            rx_seen[seq - 1] = 1'b1;
            add_beat(KIND_DELIVER, h, seq, 1'b0);
            rx_expected = (rx_expected % NSLOTS) + 1;
            for (int i = 0; i < NSLOTS - 1; i++) begin
                idx = rx_expected - 1;
                if (!rx_held[idx])
                    break;
                rx_held[idx] = 1'b0;
                add_beat(KIND_DELIVER, rx_held_hnd[idx], BYTE_W'(rx_expected), 1'b0);
                rx_expected = (rx_expected % NSLOTS) + 1;
            end
        end else begin
            idx = seq - 1;
            if (rx_seen[idx]) begin
                add_beat(KIND_DUP, h, seq, 1'b0);
            end else begin
                rx_seen[idx] = 1'b1;
                if (rx_held[idx]) begin
                    add_beat(KIND_DUP, h, seq, 1'b0);
                end else begin
                    rx_held[idx]     = 1'b1;
                    rx_held_hnd[idx] = h;
                end
            end
        end
        add_beat(KIND_ACK, '0, seq, 1'b1);
    endfunction

    task automatic check_beat();
        t_beat e;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: kind %0d handle %0h seq %0d",
                   o_kind, o_out_handle, o_out_seq);
            fails++;
        end else begin
            e = expected_beats.pop_front();
            if (o_kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, o_kind);
                fails++;
            end
            if (o_out_handle !== e.handle) begin
                $error("out_handle: expected %0h, got %0h", e.handle, o_out_handle);
                fails++;
            end
            if (o_out_seq !== e.seq) begin
                $error("out_seq: expected %0d, got %0d", e.seq, o_out_seq);
                fails++;
            end
            if (o_last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, o_last);
                fails++;
            end
        end
    endtask

    // output check first, then the new input beat, at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_beat();
            if (i_in_valid && !o_in_stall) begin
                reorder_predict(i_seq_num, i_window_num, i_buffer_handle);
                if (cur_ntyped == 2'd0) begin
                    foreach (new_beats[k])
                        expected_beats.push_back(new_beats[k]);
                end else begin
                    new_beats.delete();
                    add_beat(cur_k0, (cur_k0 == KIND_ACK) ? '0 : i_buffer_handle,
                             i_seq_num, cur_ntyped == 2'd1);
                    if (cur_ntyped == 2'd2)
                        add_beat(KIND_ACK, '0, i_seq_num, 1'b1);
                    foreach (new_beats[k])
                        expected_beats.push_back(new_beats[k]);
                end
            end
        end
    end

    // output side: random stall per mode, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_reqs != hold_served) begin
            hold_served <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (idle_mode == MODE_RX) begin
            i_out_stall <= ($urandom_range(0, 99) < 61);
        end else if (idle_mode == MODE_BOTH) begin
            i_out_stall <= ($urandom_range(0, 99) < 9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[selective_repeat_reorder_receiver] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_packet(input logic [BYTE_W-1:0] seq, input logic [BYTE_W-1:0] win,
                               input logic [HND_W-1:0] hnd, input logic [1:0] ntyped,
                               input t_kind k0, input int gap_pct);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_seq_num       <= seq;
        i_window_num    <= win;
        i_buffer_handle <= hnd;
        cur_ntyped      <= ntyped;
        cur_k0          <= k0;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin : stim
        logic [BYTE_W-1:0] rs;
        logic [BYTE_W-1:0] rw;
        int gap_pct;
        rw = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NROWS; r++)
            send_packet(DIR_ROWS[r].seq, DIR_ROWS[r].win, DIR_ROWS[r].hnd,
                        DIR_ROWS[r].ntyped, DIR_ROWS[r].k0, 0);

        for (int m = MODE_NONE; m <= MODE_BOTH; m++) begin
            idle_mode <= m;
            // long output hold-off while packets keep coming
            if (m == MODE_NONE)
                hold_reqs <= hold_reqs + 1;
            gap_pct = (m == MODE_TX) ? 61 : (m == MODE_BOTH) ? 9 : 0;
            for (int n = 0; n < ITEMS_PER_MODE; n++) begin
                if ($urandom_range(0, 9) == 0)
                    rw = BYTE_W'($urandom);
                if ($urandom_range(0, 99) < 10)
                    rs = $urandom_range(0, 1) ? 8'd0 : BYTE_W'($urandom_range(NSLOTS + 1, 255));
                else
                    rs = BYTE_W'($urandom_range(1, NSLOTS));
                send_packet(rs, rw, HND_W'($urandom), 2'd0, KIND_ACK, gap_pct);
            end
        end
        i_in_valid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fails == 0)
            $display("[selective_repeat_reorder_receiver] OK");
        else
            $display("[selective_repeat_reorder_receiver] ERROR");
        $finish;
    end

endmodule
